// File: hw/rtl/pccte_pkg.sv
// Shared types, codes and helpers of the part counter cycle time estimator.
package pccte_pkg;

   // Widths fixed by the poll and result items
   localparam int IDX_BITS     = 4;
   localparam int TIME_BITS    = 32;
   localparam int CSR_BITS     = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int MS_BITS      = 26;

   // Default parameter values
   localparam int MACHINES_DEF     = 16;
   localparam int COUNTER_BITS_DEF = 32;

   // Milliseconds per second
   localparam logic [MS_BITS-1:0] MS_PER_S = MS_BITS'(1000);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE_MASK = 3'd0,
      CSR_FIRST_DELAY = 3'd1,
      CSR_INTERVAL    = 3'd2,
      CSR_MIN_CYCLE   = 3'd3,
      CSR_TIMEOUT     = 3'd4
   } csr_idx_type;

   // Per-machine estimator phase
   typedef enum logic [2:0] {
      PH_INIT = 3'd0,
      PH_WAIT = 3'd1,
      PH_SNAP = 3'd2,
      PH_CHG1 = 3'd3,
      PH_CHG2 = 3'd4,
      PH_ERR  = 3'd5
   } phase_type;

   // Result event codes
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_OPEN    = 3'd1,
      EV_SNAP    = 3'd2,
      EV_START   = 3'd3,
      EV_ACCEPT  = 3'd4,
      EV_SHORT   = 3'd5,
      EV_CLEARED = 3'd6,
      EV_ERROR   = 3'd7
   } event_type;

   // One machine record, without the counter snapshot
   typedef struct packed {
      phase_type            phase;
      logic                 first_done;
      logic                 busy;
      logic                 result_valid;
      logic [TIME_BITS-1:0] deadline_ms;
      logic [TIME_BITS-1:0] start_ms;
      logic [TIME_BITS-1:0] result_ms;
   } rec_type;

   // Configuration as seen by one poll
   typedef struct packed {
      logic                enable;
      logic [CSR_BITS-1:0] first_delay_s;
      logic [CSR_BITS-1:0] interval_s;
      logic [CSR_BITS-1:0] min_cycle_s;
      logic [CSR_BITS-1:0] timeout_s;
   } cfg_type;

   // Seconds to milliseconds (constant multiply)
   function automatic logic [MS_BITS-1:0] ms_of(input logic [CSR_BITS-1:0] secs);
      return {{(MS_BITS-CSR_BITS){1'b0}}, secs} * MS_PER_S;
   endfunction

   // Deadline sum, saturated at the top of the time range
   function automatic logic [TIME_BITS-1:0] sat_deadline(input logic [TIME_BITS-1:0] now,
                                                         input logic [CSR_BITS-1:0]  secs);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, now} + {{(TIME_BITS+1-MS_BITS){1'b0}}, ms_of(secs)};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage

// File: hw/rtl/pccte_update.sv
// Next-state logic of one machine record for one poll.
module pccte_update #(
   parameter int COUNTER_BITS = pccte_pkg::COUNTER_BITS_DEF
) (
   input  pccte_pkg::cfg_type                    cfg,
   input  logic [pccte_pkg::TIME_BITS-1:0]       now_ms,
   input  logic [COUNTER_BITS-1:0]               cnt,
   input  logic                                  counter_ok,
   input  pccte_pkg::rec_type                    rec,
   input  logic [COUNTER_BITS-1:0]               snap,
   output pccte_pkg::rec_type                    rec_next,
   output logic [COUNTER_BITS-1:0]               snap_next,
   output pccte_pkg::event_type                  ev
);

   logic [pccte_pkg::TIME_BITS-1:0] cyc;
   logic [pccte_pkg::TIME_BITS-1:0] elapsed;
   logic [pccte_pkg::TIME_BITS-1:0] min_ms;
   logic [pccte_pkg::TIME_BITS-1:0] tmo_ms;

   assign min_ms = {{(pccte_pkg::TIME_BITS-pccte_pkg::MS_BITS){1'b0}},
                    pccte_pkg::ms_of(cfg.min_cycle_s)};
   assign tmo_ms = {{(pccte_pkg::TIME_BITS-pccte_pkg::MS_BITS){1'b0}},
                    pccte_pkg::ms_of(cfg.timeout_s)};
   assign cyc    = now_ms - rec.start_ms;

   // Advance the phase, then apply the timeout over the updated record
   always_comb begin
      rec_next  = rec;
      snap_next = snap;
      ev        = pccte_pkg::EV_NONE;
      case (rec.phase)
         pccte_pkg::PH_INIT: begin
            if (cfg.enable) begin
               if (!rec.first_done) begin
                  rec_next.first_done  = 1'b1;
                  rec_next.deadline_ms = pccte_pkg::sat_deadline(now_ms, cfg.first_delay_s);
               end else begin
                  rec_next.deadline_ms = pccte_pkg::sat_deadline(now_ms, cfg.interval_s);
               end
               rec_next.phase = pccte_pkg::PH_WAIT;
            end
         end
         pccte_pkg::PH_WAIT: begin
            if (now_ms > rec.deadline_ms) begin
               rec_next.phase = pccte_pkg::PH_SNAP;
               ev             = pccte_pkg::EV_OPEN;
            end
         end
         pccte_pkg::PH_SNAP: begin
            if (!counter_ok) begin
               rec_next.phase = pccte_pkg::PH_ERR;
               ev             = pccte_pkg::EV_ERROR;
            end else begin
               snap_next      = cnt;
               rec_next.phase = pccte_pkg::PH_CHG1;
               ev             = pccte_pkg::EV_SNAP;
            end
         end
         pccte_pkg::PH_CHG1: begin
            if (!counter_ok) begin
               rec_next.phase = pccte_pkg::PH_ERR;
               ev             = pccte_pkg::EV_ERROR;
            end else if (cnt != snap) begin
               snap_next         = cnt;
               rec_next.start_ms = now_ms;
               rec_next.busy     = 1'b1;
               rec_next.phase    = pccte_pkg::PH_CHG2;
               ev                = pccte_pkg::EV_START;
            end
         end
         pccte_pkg::PH_CHG2: begin
            if (!counter_ok) begin
               rec_next.phase = pccte_pkg::PH_ERR;
               ev             = pccte_pkg::EV_ERROR;
            end else if (cnt != snap) begin
               if (now_ms < rec.start_ms) begin
                  // time went backwards
                  rec_next.phase = pccte_pkg::PH_ERR;
                  ev             = pccte_pkg::EV_ERROR;
               end else begin
                  if (cyc > min_ms) begin
                     rec_next.result_ms    = cyc;
                     rec_next.result_valid = 1'b1;
                     ev                    = pccte_pkg::EV_ACCEPT;
                  end else begin
                     ev = pccte_pkg::EV_SHORT;
                  end
                  rec_next.busy  = 1'b0;
                  rec_next.phase = pccte_pkg::PH_INIT;
               end
            end
         end
         default: begin
            // error phase: drop the estimate and start over
            rec_next.result_valid = 1'b0;
            rec_next.busy         = 1'b0;
            rec_next.phase        = pccte_pkg::PH_INIT;
            ev                    = pccte_pkg::EV_CLEARED;
         end
      endcase

      elapsed = now_ms - rec_next.start_ms;
      if (rec_next.busy && (now_ms > rec_next.start_ms) && (elapsed > tmo_ms)) begin
         rec_next.phase = pccte_pkg::PH_ERR;
         ev             = pccte_pkg::EV_ERROR;
      end
   end

endmodule

// File: hw/rtl/pccte_store.sv
// Per-machine records, counter snapshots and busy flags.
module pccte_store #(
   parameter int SLOTS        = pccte_pkg::MACHINES_DEF,
   parameter int SLOT_W       = 4,
   parameter int COUNTER_BITS = pccte_pkg::COUNTER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [SLOT_W-1:0]         slot,
   input  logic                      wr_en,
   input  pccte_pkg::rec_type        wr_rec,
   input  logic [COUNTER_BITS-1:0]   wr_snap,
   output pccte_pkg::rec_type        rd_rec,
   output logic [COUNTER_BITS-1:0]   rd_snap,
   output logic [SLOTS-1:0]          busy_vec
);

   pccte_pkg::rec_type        rec_ff  [SLOTS];
   logic [COUNTER_BITS-1:0]   snap_ff [SLOTS];

   // Write back the updated record of the polled machine
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            rec_ff[s]  <= '0;
            snap_ff[s] <= '0;
         end
      end else if (wr_en) begin
         rec_ff[slot]  <= wr_rec;
         snap_ff[slot] <= wr_snap;
      end
   end

   assign rd_rec  = rec_ff[slot];
   assign rd_snap = snap_ff[slot];

   // Gather the busy flags
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         busy_vec[s] = rec_ff[s].busy;
      end
   end

endmodule

// File: hw/rtl/part_counter_cycle_time_estimator_unit.sv
// A poll is captured in the input register, its machine record is updated, and its result waits in the result register.
// Throughput: one poll per cycle while the result channel does not stall; the bound is the read-update-write
// of the polled machine's record, so polls of the same machine may follow back to back.
// Reset: synchronous, active high; clears all machine records at once, restores the
// register defaults and empties both pipeline registers. No clearing pass is needed.
// Top level of the part counter cycle time estimator.
module part_counter_cycle_time_estimator_unit #(
   parameter int MACHINES     = pccte_pkg::MACHINES_DEF,
   parameter int COUNTER_BITS = pccte_pkg::COUNTER_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // poll channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pccte_pkg::IDX_BITS-1:0]       req_machine_index,
   input  logic [pccte_pkg::TIME_BITS-1:0]      req_now_ms,
   input  logic [31:0]                          req_counter_value,
   input  logic                                 req_counter_ok,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pccte_pkg::IDX_BITS-1:0]       rsp_machine_echo,
   output logic [2:0]                           rsp_event_code,
   output logic                                 rsp_estimate_ok,
   output logic [pccte_pkg::TIME_BITS-1:0]      rsp_cycle_ms,
   output logic                                 rsp_measuring,
   output logic                                 rsp_any_measuring,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pccte_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pccte_pkg::CSR_BITS-1:0]       csr_data
);

   localparam int REACH  = 2 ** pccte_pkg::IDX_BITS;
   localparam int SLOTS  = (MACHINES < REACH) ? MACHINES : REACH;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // configuration registers
   logic [pccte_pkg::CSR_BITS-1:0] enable_mask_ff;
   logic [pccte_pkg::CSR_BITS-1:0] first_delay_ff;
   logic [pccte_pkg::CSR_BITS-1:0] interval_ff;
   logic [pccte_pkg::CSR_BITS-1:0] min_cycle_ff;
   logic [pccte_pkg::CSR_BITS-1:0] timeout_ff;

   // input register
   logic                               in_valid_ff;
   logic [pccte_pkg::IDX_BITS-1:0]     idx_ff;
   logic [pccte_pkg::TIME_BITS-1:0]    now_ff;
   logic [31:0]                        cnt_ff;
   logic                               ok_ff;

   // result register
   logic                               out_valid_ff;
   logic [pccte_pkg::IDX_BITS-1:0]     echo_ff;
   pccte_pkg::event_type               event_ff;
   logic                               est_ok_ff;
   logic [pccte_pkg::TIME_BITS-1:0]    cycle_ff;
   logic                               meas_ff;
   logic                               any_ff;

   logic                               req_xfer;
   logic                               advance;
   logic                               in_range;
   logic [SLOT_W-1:0]                  slot;
   logic [63:0]                        cnt_wide;
   logic [COUNTER_BITS-1:0]            cnt;
   pccte_pkg::cfg_type                 cfg;
   pccte_pkg::rec_type                 rd_rec;
   pccte_pkg::rec_type                 new_rec;
   logic [COUNTER_BITS-1:0]            rd_snap;
   logic [COUNTER_BITS-1:0]            new_snap;
   pccte_pkg::event_type               new_ev;
   logic [SLOTS-1:0]                   busy_vec;
   logic                               any_in;
   pccte_pkg::event_type               event_in;
   logic                               est_ok_in;
   logic [pccte_pkg::TIME_BITS-1:0]    cycle_in;
   logic                               meas_in;

   // Handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= '0;
         first_delay_ff <= pccte_pkg::CSR_BITS'(60);
         interval_ff    <= pccte_pkg::CSR_BITS'(3600);
         min_cycle_ff   <= pccte_pkg::CSR_BITS'(1);
         timeout_ff     <= pccte_pkg::CSR_BITS'(3600);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pccte_pkg::CSR_ENABLE_MASK: enable_mask_ff <= csr_data;
            pccte_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_data;
            pccte_pkg::CSR_INTERVAL:    interval_ff    <= csr_data;
            pccte_pkg::CSR_MIN_CYCLE:   min_cycle_ff   <= csr_data;
            pccte_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the poll on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_xfer || (in_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         idx_ff <= req_machine_index;
         now_ff <= req_now_ms;
         cnt_ff <= req_counter_value;
         ok_ff  <= req_counter_ok;
      end
   end

   // Decode the polled machine
   assign in_range = {{(32-pccte_pkg::IDX_BITS){1'b0}}, idx_ff} < 32'(MACHINES);
   assign slot     = idx_ff[SLOT_W-1:0];
   assign cnt_wide = {32'd0, cnt_ff};
   assign cnt      = cnt_wide[COUNTER_BITS-1:0];

   always_comb begin
      cfg.enable        = enable_mask_ff[idx_ff];
      cfg.first_delay_s = first_delay_ff;
      cfg.interval_s    = interval_ff;
      cfg.min_cycle_s   = min_cycle_ff;
      cfg.timeout_s     = timeout_ff;
   end

   pccte_store #(
      .SLOTS        (SLOTS),
      .SLOT_W       (SLOT_W),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .slot     (slot),
      .wr_en    (advance && in_range),
      .wr_rec   (new_rec),
      .wr_snap  (new_snap),
      .rd_rec   (rd_rec),
      .rd_snap  (rd_snap),
      .busy_vec (busy_vec)
   );

   pccte_update #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_update (
      .cfg        (cfg),
      .now_ms     (now_ff),
      .cnt        (cnt),
      .counter_ok (ok_ff),
      .rec        (rd_rec),
      .snap       (rd_snap),
      .rec_next   (new_rec),
      .snap_next  (new_snap),
      .ev         (new_ev)
   );

   // Form the result; busy flags are taken after this poll's update
   always_comb begin
      any_in = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         if (in_range && (slot == SLOT_W'(s))) begin
            any_in = any_in | new_rec.busy;
         end else begin
            any_in = any_in | busy_vec[s];
         end
      end
      if (in_range) begin
         event_in  = new_ev;
         est_ok_in = new_rec.result_valid;
         cycle_in  = new_rec.result_valid ? new_rec.result_ms : '0;
         meas_in   = new_rec.busy;
      end else begin
         event_in  = pccte_pkg::EV_NONE;
         est_ok_in = 1'b0;
         cycle_in  = '0;
         meas_in   = 1'b0;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= advance || (out_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         echo_ff   <= idx_ff;
         event_ff  <= event_in;
         est_ok_ff <= est_ok_in;
         cycle_ff  <= cycle_in;
         meas_ff   <= meas_in;
         any_ff    <= any_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_machine_echo  = echo_ff;
   assign rsp_event_code    = event_ff;
   assign rsp_estimate_ok   = est_ok_ff;
   assign rsp_cycle_ms      = cycle_ff;
   assign rsp_measuring     = meas_ff;
   assign rsp_any_measuring = any_ff;

endmodule

// File: hw/rtl/pccte_checker.sv
// Port-level checks of the estimator and their binding to the top level.
module pccte_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [pccte_pkg::IDX_BITS-1:0]    rsp_machine_echo,
   input logic [2:0]                        rsp_event_code,
   input logic                              rsp_estimate_ok,
   input logic [pccte_pkg::TIME_BITS-1:0]   rsp_cycle_ms,
   input logic                              rsp_measuring,
   input logic                              rsp_any_measuring
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_cycle_ms) && $stable(rsp_machine_echo))
      else $error("stalled result changed");

   // A measuring machine makes the global flag high
   a_any_meas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_measuring |-> rsp_any_measuring)
      else $error("measuring without any_measuring");

   // Timing start leaves the machine measuring
   a_start_meas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == pccte_pkg::EV_START) |-> rsp_measuring)
      else $error("timing started but not measuring");

   // An accepted estimate is valid and nonzero; no estimate reads as zero
   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == pccte_pkg::EV_ACCEPT)
         |-> rsp_estimate_ok && (rsp_cycle_ms != '0) && !rsp_measuring)
      else $error("accepted estimate not reported");

   a_no_est_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_estimate_ok |-> rsp_cycle_ms == '0)
      else $error("cycle time shown without estimate");

endmodule

bind part_counter_cycle_time_estimator_unit pccte_checker u_pccte_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_machine_echo  (rsp_machine_echo),
   .rsp_event_code    (rsp_event_code),
   .rsp_estimate_ok   (rsp_estimate_ok),
   .rsp_cycle_ms      (rsp_cycle_ms),
   .rsp_measuring     (rsp_measuring),
   .rsp_any_measuring (rsp_any_measuring)
);

// File: dv/testbench.sv
// Self-checking testbench for the part counter cycle time estimator unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MACH_TOTAL        = 16;
   localparam int RUN_SETTINGS      = 10;
   localparam int POLLS_PER_SETTING = 125;
   localparam int IDLE_PERCENT      = 19;
   localparam int HOLD_CYCLES       = 200;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam logic [2:0] CSR_IDX_SPARE = 3'd5;
   localparam longint unsigned MS_IN_S = 1000;

   typedef enum logic {ROW_POLL, ROW_REG} row_kind_type;

   // One result as seen on the result channel
   typedef struct packed {
      logic [3:0]           machine;
      pccte_pkg::event_type ev;
      logic                 est_ok;
      logic [31:0]          cycle;
      logic                 meas;
      logic                 any;
   } poll_result_type;

   // One line of the directed script
   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_index;
      logic [15:0]     reg_data;
      logic [3:0]      machine;
      logic [31:0]     now;
      logic [31:0]     count;
      logic            ok;
      bit              typed;
      poll_result_type want;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_machine_index = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_counter_value = '0;
   logic        req_counter_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_machine_echo;
   logic [2:0]  rsp_event_code;
   logic        rsp_estimate_ok;
   logic [31:0] rsp_cycle_ms;
   logic        rsp_measuring;
   logic        rsp_any_measuring;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Predictor copy of the configuration
   logic [15:0] cfg_enable = 16'd0;
   logic [15:0] cfg_first_delay = 16'd60;
   logic [15:0] cfg_interval = 16'd3600;
   logic [15:0] cfg_min_cycle = 16'd1;
   logic [15:0] cfg_timeout = 16'd3600;

   // Predictor copy of the machine records
   pccte_pkg::phase_type mach_phase [MACH_TOTAL];
   bit          armed_once [MACH_TOTAL];
   logic [31:0] win_deadline [MACH_TOTAL];
   logic [31:0] count_snap [MACH_TOTAL];
   logic [31:0] start_time [MACH_TOTAL];
   bit          timing [MACH_TOTAL];
   bit          est_valid [MACH_TOTAL];
   logic [31:0] est_ms [MACH_TOTAL];

   poll_result_type poll_outcomes [$];
   int  error_count = 0;
   int  polls_sent = 0;
   int  results_checked = 0;
   int  settings_applied = 0;
   int  event_hits [8];
   bit  no_idle = 1'b0;
   bit  hold_req = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   part_counter_cycle_time_estimator_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_machine_index (req_machine_index),
      .req_now_ms        (req_now_ms),
      .req_counter_value (req_counter_value),
      .req_counter_ok    (req_counter_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_machine_echo  (rsp_machine_echo),
      .rsp_event_code    (rsp_event_code),
      .rsp_estimate_ok   (rsp_estimate_ok),
      .rsp_cycle_ms      (rsp_cycle_ms),
      .rsp_measuring     (rsp_measuring),
      .rsp_any_measuring (rsp_any_measuring),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Window deadline: now plus whole seconds, pinned at the top of the time range
   function automatic logic [31:0] deadline_after(input logic [31:0] now,
                                                  input logic [15:0] secs);
      logic [32:0] sum;
      sum = {1'b0, now} + 33'(secs) * 33'd1000;
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Advance one machine's estimator by one poll and return the result it gives
   function automatic poll_result_type estimate_poll(input logic [3:0] m,
                                                     input logic [31:0] now,
                                                     input logic [31:0] cnt,
                                                     input logic ok);
      poll_result_type      res;
      pccte_pkg::event_type ev;
      logic [31:0]          cyc;
      bit                   any;
      ev = pccte_pkg::EV_NONE;
      any = 1'b0;
      case (mach_phase[m])
         pccte_pkg::PH_INIT: begin
            if (cfg_enable[m]) begin
               if (!armed_once[m]) begin
                  armed_once[m] = 1'b1;
                  win_deadline[m] = deadline_after(now, cfg_first_delay);
               end else begin
                  win_deadline[m] = deadline_after(now, cfg_interval);
               end
               mach_phase[m] = pccte_pkg::PH_WAIT;
            end
         end
         pccte_pkg::PH_WAIT: begin
            if (now > win_deadline[m]) begin
               mach_phase[m] = pccte_pkg::PH_SNAP;
               ev = pccte_pkg::EV_OPEN;
            end
         end
         pccte_pkg::PH_SNAP: begin
            if (!ok) begin
               mach_phase[m] = pccte_pkg::PH_ERR;
               ev = pccte_pkg::EV_ERROR;
            end else begin
               count_snap[m] = cnt;
               mach_phase[m] = pccte_pkg::PH_CHG1;
               ev = pccte_pkg::EV_SNAP;
            end
         end
         pccte_pkg::PH_CHG1: begin
            if (!ok) begin
               mach_phase[m] = pccte_pkg::PH_ERR;
               ev = pccte_pkg::EV_ERROR;
            end else if (cnt != count_snap[m]) begin
               count_snap[m] = cnt;
               start_time[m] = now;
               timing[m] = 1'b1;
               mach_phase[m] = pccte_pkg::PH_CHG2;
               ev = pccte_pkg::EV_START;
            end
         end
         pccte_pkg::PH_CHG2: begin
            if (!ok) begin
               mach_phase[m] = pccte_pkg::PH_ERR;
               ev = pccte_pkg::EV_ERROR;
            end else if (cnt != count_snap[m]) begin
               if (now < start_time[m]) begin
                  mach_phase[m] = pccte_pkg::PH_ERR;
                  ev = pccte_pkg::EV_ERROR;
               end else begin
                  cyc = now - start_time[m];
                  if (64'(cyc) > 64'(cfg_min_cycle) * MS_IN_S) begin
                     est_ms[m] = cyc;
                     est_valid[m] = 1'b1;
                     ev = pccte_pkg::EV_ACCEPT;
                  end else begin
                     ev = pccte_pkg::EV_SHORT;
                  end
                  timing[m] = 1'b0;
                  mach_phase[m] = pccte_pkg::PH_INIT;
               end
            end
         end
         default: begin
            est_valid[m] = 1'b0;
            timing[m] = 1'b0;
            mach_phase[m] = pccte_pkg::PH_INIT;
            ev = pccte_pkg::EV_CLEARED;
         end
      endcase
      // timeout overrides whatever this poll did
      if (timing[m] && now > start_time[m] &&
          64'(now - start_time[m]) > 64'(cfg_timeout) * MS_IN_S) begin
         mach_phase[m] = pccte_pkg::PH_ERR;
         ev = pccte_pkg::EV_ERROR;
      end
      for (int i = 0; i < MACH_TOTAL; i++)
         if (timing[i])
            any = 1'b1;
      event_hits[ev]++;
      res.machine = m;
      res.ev = ev;
      res.est_ok = est_valid[m];
      res.cycle = est_valid[m] ? est_ms[m] : 32'd0;
      res.meas = timing[m];
      res.any = any;
      return res;
   endfunction

   function automatic step_row_type poll_row(input logic [3:0] m, input logic [31:0] now,
                                             input logic [31:0] cnt, input logic ok,
                                             input bit typed, input pccte_pkg::event_type ev,
                                             input logic est, input logic [31:0] cyc,
                                             input logic meas, input logic any);
      step_row_type row;
      row.kind = ROW_POLL;
      row.reg_index = '0;
      row.reg_data = '0;
      row.machine = m;
      row.now = now;
      row.count = cnt;
      row.ok = ok;
      row.typed = typed;
      row.want = '{machine: m, ev: ev, est_ok: est, cycle: cyc, meas: meas, any: any};
      return row;
   endfunction

   function automatic step_row_type reg_row(input logic [2:0] idx, input logic [15:0] data);
      step_row_type row;
      row = poll_row(4'd0, 32'd0, 32'd0, 1'b0, 1'b0, pccte_pkg::EV_NONE,
                     1'b0, 32'd0, 1'b0, 1'b0);
      row.kind = ROW_REG;
      row.reg_index = idx;
      row.reg_data = data;
      return row;
   endfunction

   // Offer one poll, with an optional gap first; hold it until transferred
   task automatic send_poll(input logic [3:0] m, input logic [31:0] now, input logic [31:0] cnt,
                            input logic ok, input bit typed,
                            input poll_result_type typed_want);
      poll_result_type want;
      int gap;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_machine_index <= m;
      req_now_ms <= now;
      req_counter_value <= cnt;
      req_counter_ok <= ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = estimate_poll(m, now, cnt, ok);
      if (typed)
         want = typed_want;
      poll_outcomes.push_back(want);
      polls_sent++;
   endtask

   // Stop offering polls and wait for every outstanding result
   task automatic quiesce();
      req_valid <= 1'b0;
      while (poll_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one register; valid is left high for a following write
   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pccte_pkg::CSR_ENABLE_MASK: cfg_enable = data;
         pccte_pkg::CSR_FIRST_DELAY: cfg_first_delay = data;
         pccte_pkg::CSR_INTERVAL:    cfg_interval = data;
         pccte_pkg::CSR_MIN_CYCLE:   cfg_min_cycle = data;
         pccte_pkg::CSR_TIMEOUT:     cfg_timeout = data;
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      end
   endtask

   // Result side: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Compare each transferred result with the oldest prediction
   always @(posedge clock) begin
      poll_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (poll_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: result for machine %0d with none expected", $time, rsp_machine_echo);
         end else begin
            want = poll_outcomes.pop_front();
            check_field("machine_echo", 32'(want.machine), 32'(rsp_machine_echo));
            check_field("event_code", 32'(want.ev), 32'(rsp_event_code));
            check_field("estimate_ok", 32'(want.est_ok), 32'(rsp_estimate_ok));
            check_field("cycle_ms", want.cycle, rsp_cycle_ms);
            check_field("measuring", 32'(want.meas), 32'(rsp_measuring));
            check_field("any_measuring", 32'(want.any), 32'(rsp_any_measuring));
            results_checked++;
         end
      end
   end

   // Watchdog: end the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, poll_outcomes.size());
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed script, then random settings with random polls
   initial begin
      step_row_type    script [$];
      step_row_type    row;
      bit              in_regs;
      int              pick;
      logic [3:0]      m;
      logic [3:0]      hot [4];
      logic [31:0]     tm;
      logic [31:0]     now_v;
      logic [31:0]     cnt_v;
      logic            ok_v;
      logic [31:0]     part_count [MACH_TOTAL];
      poll_result_type no_want;

      for (int i = 0; i < MACH_TOTAL; i++) begin
         mach_phase[i] = pccte_pkg::PH_INIT;
         armed_once[i] = 1'b0;
         win_deadline[i] = '0;
         count_snap[i] = '0;
         start_time[i] = '0;
         timing[i] = 1'b0;
         est_valid[i] = 1'b0;
         est_ms[i] = '0;
         part_count[i] = $urandom;
      end
      for (int i = 0; i < 8; i++)
         event_hits[i] = 0;
      no_want = '0;

      // disabled after reset, then full mask with zero delays
      script.push_back(poll_row(4'd0, 32'd0, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(reg_row(pccte_pkg::CSR_ENABLE_MASK, 16'hFFFF));
      script.push_back(reg_row(pccte_pkg::CSR_FIRST_DELAY, 16'd0));
      script.push_back(reg_row(pccte_pkg::CSR_INTERVAL, 16'd0));
      // invalid counter at the snapshot, then the error clears
      script.push_back(poll_row(4'd0, 32'd100, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd101, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_OPEN,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd102, 32'd5, 1'b0, 1'b1, pccte_pkg::EV_ERROR,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd103, 32'd5, 1'b1, 1'b1, pccte_pkg::EV_CLEARED,
                                1'b0, 32'd0, 1'b0, 1'b0));
      // full measurement, counter wraps from all ones to zero
      script.push_back(poll_row(4'd0, 32'd200, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd201, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_OPEN,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd202, 32'hFFFF_FFFF, 1'b1, 1'b1, pccte_pkg::EV_SNAP,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd0, 32'd1000, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_START,
                                1'b0, 32'd0, 1'b1, 1'b1));
      script.push_back(poll_row(4'd0, 32'd2001, 32'd1, 1'b1, 1'b1, pccte_pkg::EV_ACCEPT,
                                1'b1, 32'd1001, 1'b0, 1'b0));
      // cycle exactly at the minimum is too short
      script.push_back(poll_row(4'd1, 32'd3000, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd1, 32'd3001, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_OPEN,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd1, 32'd3002, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_SNAP,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd1, 32'd4000, 32'd1, 1'b1, 1'b1, pccte_pkg::EV_START,
                                1'b0, 32'd0, 1'b1, 1'b1));
      script.push_back(poll_row(4'd1, 32'd5000, 32'd2, 1'b1, 1'b1, pccte_pkg::EV_SHORT,
                                1'b0, 32'd0, 1'b0, 1'b0));
      // time going backwards at the second change
      script.push_back(poll_row(4'd2, 32'd6000, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd2, 32'd6001, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_OPEN,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd2, 32'd6002, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_SNAP,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd2, 32'd7000, 32'd1, 1'b1, 1'b1, pccte_pkg::EV_START,
                                1'b0, 32'd0, 1'b1, 1'b1));
      script.push_back(poll_row(4'd2, 32'd6500, 32'd2, 1'b1, 1'b1, pccte_pkg::EV_ERROR,
                                1'b0, 32'd0, 1'b1, 1'b1));
      // timeout one millisecond past the limit
      script.push_back(poll_row(4'd15, 32'd8000, 32'd0, 1'b1, 1'b0, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd15, 32'd8001, 32'd0, 1'b1, 1'b0, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd15, 32'd8002, 32'd0, 1'b1, 1'b0, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd15, 32'd9000, 32'd1, 1'b1, 1'b0, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b0));
      script.push_back(poll_row(4'd15, 32'd3609001, 32'd1, 1'b1, 1'b1, pccte_pkg::EV_ERROR,
                                1'b0, 32'd0, 1'b1, 1'b1));
      // saturated deadline is never passed
      script.push_back(reg_row(pccte_pkg::CSR_FIRST_DELAY, 16'hFFFF));
      script.push_back(poll_row(4'd8, 32'hFFFF_FFF0, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b1));
      script.push_back(poll_row(4'd8, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, pccte_pkg::EV_NONE,
                                1'b0, 32'd0, 1'b0, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed script
      in_regs = 1'b0;
      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_REG) begin
            if (!in_regs) begin
               quiesce();
               in_regs = 1'b1;
            end
            csr_write(row.reg_index, row.reg_data);
         end else begin
            if (in_regs) begin
               csr_valid <= 1'b0;
               in_regs = 1'b0;
               settings_applied++;
            end
            send_poll(row.machine, row.now, row.count, row.ok, row.typed, row.want);
         end
      end

      // Random settings, each followed by a burst of polls
      tm = 32'd5_000_000;
      for (int setting = 0; setting < RUN_SETTINGS; setting++) begin
         quiesce();
         case (setting)
            3: begin
               csr_write(pccte_pkg::CSR_ENABLE_MASK, 16'hFFFF);
               csr_write(pccte_pkg::CSR_FIRST_DELAY, 16'd0);
               csr_write(pccte_pkg::CSR_INTERVAL, 16'd0);
               csr_write(pccte_pkg::CSR_MIN_CYCLE, 16'd0);
               csr_write(pccte_pkg::CSR_TIMEOUT, 16'd0);
            end
            8: begin
               csr_write(pccte_pkg::CSR_ENABLE_MASK, 16'($urandom));
               csr_write(pccte_pkg::CSR_FIRST_DELAY, 16'($urandom));
               csr_write(pccte_pkg::CSR_INTERVAL, 16'($urandom));
               csr_write(pccte_pkg::CSR_MIN_CYCLE, 16'($urandom));
               csr_write(pccte_pkg::CSR_TIMEOUT, 16'($urandom));
            end
            9: begin
               csr_write(pccte_pkg::CSR_ENABLE_MASK, 16'hFFFF);
               csr_write(pccte_pkg::CSR_FIRST_DELAY, 16'hFFFF);
               csr_write(pccte_pkg::CSR_INTERVAL, 16'hFFFF);
               csr_write(pccte_pkg::CSR_MIN_CYCLE, 16'hFFFF);
               csr_write(pccte_pkg::CSR_TIMEOUT, 16'hFFFF);
            end
            default: begin
               // a cleared mask leaves machines already in flight running on
               csr_write(pccte_pkg::CSR_ENABLE_MASK,
                         (setting == 6) ? 16'h0000 : 16'($urandom | $urandom));
               csr_write(pccte_pkg::CSR_FIRST_DELAY, 16'($urandom_range(0, 3)));
               csr_write(pccte_pkg::CSR_INTERVAL, 16'($urandom_range(0, 5)));
               csr_write(pccte_pkg::CSR_MIN_CYCLE, 16'($urandom_range(0, 8)));
               csr_write(pccte_pkg::CSR_TIMEOUT, 16'($urandom_range(4, 30)));
            end
         endcase
         // writes to unused indexes must change nothing
         if ($urandom_range(0, 1) == 1)
            csr_write(CSR_IDX_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
         csr_valid <= 1'b0;
         settings_applied++;
         no_idle <= (setting == 4 || setting == 5);
         if (setting == 1)
            hold_req <= 1'b1;
         for (int k = 0; k < 4; k++)
            hot[k] = 4'($urandom_range(0, MACH_TOTAL - 1));

         for (int item = 0; item < POLLS_PER_SETTING; item++) begin
            pick = $urandom_range(0, 99);
            m = (pick < 70) ? hot[pick % 4] : 4'($urandom_range(0, MACH_TOTAL - 1));
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
               // rare fully random poll
               now_v = $urandom;
               cnt_v = $urandom;
               ok_v = 1'($urandom_range(0, 1));
            end else begin
               if (pick < 5 && tm > 32'd3000)
                  tm = tm - $urandom_range(0, 3000);
               else
                  tm = tm + $urandom_range(0, 900);
               if ($urandom_range(0, 2) == 0)
                  part_count[m] = part_count[m] + $urandom_range(1, 3);
               now_v = tm;
               cnt_v = part_count[m];
               ok_v = ($urandom_range(0, 99) >= 3);
            end
            send_poll(m, now_v, cnt_v, ok_v, 1'b0, no_want);
         end
      end

      // Drain and let the pipeline settle
      req_valid <= 1'b0;
      while (poll_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d polls over %0d register settings, %0d results checked",
               polls_sent, settings_applied, results_checked);
      $display("summary: window %0d, snapshot %0d, start %0d, accepted %0d, short %0d,",
               event_hits[pccte_pkg::EV_OPEN], event_hits[pccte_pkg::EV_SNAP],
               event_hits[pccte_pkg::EV_START], event_hits[pccte_pkg::EV_ACCEPT],
               event_hits[pccte_pkg::EV_SHORT]);
      $display("summary: cleared %0d, error %0d",
               event_hits[pccte_pkg::EV_CLEARED], event_hits[pccte_pkg::EV_ERROR]);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
